// ===== src/u8drs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8drs_pkg
// shared types, constants and helper functions of the utf-8 rune search unit
// ----------------------------------------------------------------------------
package u8drs_pkg;

  localparam int CP_W          = 21;
  localparam int SIZE_W        = 3;
  localparam int INDEX_W_DEF   = 16;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 21;
  localparam int OUT_USER_W    = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CASE   = 1'b1;

  localparam logic [7:0]      CONT_CLASS   = 8'h80;
  localparam logic [7:0]      LEAD2_BASE   = 8'hC0;
  localparam logic [7:0]      LEAD3_BASE   = 8'hE0;
  localparam logic [7:0]      LEAD4_BASE   = 8'hF0;
  localparam logic [7:0]      LEAD_END     = 8'hF8;
  localparam logic [7:0]      PAYLOAD_MASK = 8'h3F;
  localparam logic [7:0]      ASCII_MASK   = 8'h7F;
  localparam logic [CP_W-1:0] CHAR_UPPER_A = CP_W'(8'h41);
  localparam logic [CP_W-1:0] CHAR_UPPER_Z = CP_W'(8'h5A);
  localparam logic [CP_W-1:0] CHAR_LOWER_A = CP_W'(8'h61);

  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_of_string;
  } item_t;

  typedef struct packed {
    logic [CP_W-1:0]   code_point;
    logic [SIZE_W-1:0] char_size;
    logic              is_match;
    logic              first_match_res;
    logic              bad_lead;
    logic              truncated;
    logic              last;
    logic              any_found;
  } res_t;

  // sequence length from the lead byte, 0 for a byte that cannot lead
  function automatic logic [SIZE_W-1:0] lead_size(input logic [7:0] b);
    logic [SIZE_W-1:0] s;
    if (b < CONT_CLASS)      s = 3'd1;
    else if (b < LEAD2_BASE) s = 3'd0;
    else if (b < LEAD3_BASE) s = 3'd2;
    else if (b < LEAD4_BASE) s = 3'd3;
    else if (b < LEAD_END)   s = 3'd4;
    else                     s = 3'd0;
    return s;
  endfunction

  // ascii-only lower casing
  function automatic logic [CP_W-1:0] fold_lower(input logic [CP_W-1:0] c);
    logic [CP_W-1:0] r;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) r = c - CHAR_UPPER_A + CHAR_LOWER_A;
    else                                        r = c;
    return r;
  endfunction

endpackage

// ===== src/u8drs_in_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8drs_in_reg
// input register stage for incoming byte requests
// ----------------------------------------------------------------------------
module u8drs_in_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  u8drs_pkg::item_t s_item,
  output logic           item_valid,
  output u8drs_pkg::item_t item,
  input  logic           advance
);
  import u8drs_pkg::*;

  assign s_tready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item <= s_item;
    end
  end

endmodule

// ===== src/u8drs_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8drs_core
// decode state, configuration registers and per-byte decode and compare
// ----------------------------------------------------------------------------
module u8drs_core #(
  parameter int INDEX_WIDTH = u8drs_pkg::INDEX_W_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [u8drs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [u8drs_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                              item_valid,
  input  u8drs_pkg::item_t                  item,
  input  logic                              out_ready,
  output logic                              advance,
  output logic                              res_valid,
  output u8drs_pkg::res_t                   res,
  output logic [INDEX_WIDTH-1:0]            res_index
);
  import u8drs_pkg::*;

  logic [CP_W-1:0]        target_code_point;
  logic                   case_sensitive;
  logic [1:0]             bytes_remaining, bytes_remaining_next;
  logic [SIZE_W-1:0]      sequence_size, sequence_size_next;
  logic [CP_W-1:0]        partial_value, partial_value_next;
  logic [INDEX_WIDTH-1:0] char_counter;
  logic                   found_flag;

  logic [SIZE_W-1:0] lsize;
  logic [CP_W-1:0]   cp;
  logic [SIZE_W-1:0] size;
  logic              done, bad, trunc, match;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_code_point <= '0;
      case_sensitive    <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TARGET: target_code_point <= cfg_data[CP_W-1:0];
        CFG_CASE:   case_sensitive    <= cfg_data[0];
      endcase
    end
  end

  assign advance = item_valid && out_ready;
  assign lsize   = lead_size(item.byte_in);

  always_comb begin
    bytes_remaining_next = bytes_remaining;
    sequence_size_next   = sequence_size;
    partial_value_next   = partial_value;
    done  = 1'b0;
    bad   = 1'b0;
    trunc = 1'b0;
    cp    = '0;
    size  = '0;
    if (bytes_remaining != 2'd0) begin
      partial_value_next   = {partial_value[CP_W-7:0], item.byte_in[5:0] & PAYLOAD_MASK[5:0]};
      bytes_remaining_next = bytes_remaining - 2'd1;
      if (bytes_remaining == 2'd1) begin
        done = 1'b1;
        cp   = partial_value_next;
        size = sequence_size;
      end
    end else begin
      case (lsize)
        3'd0: begin
          done = 1'b1;
          bad  = 1'b1;
        end
        3'd1: begin
          done = 1'b1;
          cp   = CP_W'(item.byte_in & ASCII_MASK);
          size = 3'd1;
        end
        default: begin
          sequence_size_next   = lsize;
          bytes_remaining_next = 2'(lsize - 3'd1);
          partial_value_next   = CP_W'(item.byte_in & (ASCII_MASK >> lsize));
        end
      endcase
    end
    // string ends inside a sequence
    if (!done && item.end_of_string) begin
      done  = 1'b1;
      trunc = 1'b1;
      cp    = partial_value_next;
      size  = sequence_size_next;
    end
  end

  always_comb begin
    if (bad || trunc)        match = 1'b0;
    else if (case_sensitive) match = (cp == target_code_point);
    else                     match = (fold_lower(cp) == fold_lower(target_code_point));
  end

  assign res_valid           = done;
  assign res_index           = char_counter;
  assign res.code_point      = cp;
  assign res.char_size       = size;
  assign res.is_match        = match;
  assign res.first_match_res = match && !found_flag;
  assign res.bad_lead        = bad;
  assign res.truncated       = trunc;
  assign res.last            = item.end_of_string;
  assign res.any_found       = found_flag || match;

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_remaining <= '0;
      sequence_size   <= '0;
      partial_value   <= '0;
      char_counter    <= '0;
      found_flag      <= 1'b0;
    end else if (advance) begin
      if (item.end_of_string) begin
        bytes_remaining <= '0;
        sequence_size   <= '0;
        partial_value   <= '0;
        char_counter    <= '0;
        found_flag      <= 1'b0;
      end else begin
        bytes_remaining <= bytes_remaining_next;
        sequence_size   <= sequence_size_next;
        partial_value   <= partial_value_next;
        if (done) begin
          found_flag <= found_flag || match;
          // index saturates at all ones
          if (!(&char_counter)) char_counter <= char_counter + 1'b1;
        end
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_bad_not_trunc: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res.bad_lead && res.truncated))
    else $error("bad lead and truncation reported together");

  a_first_is_match: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.first_match_res |-> res.is_match && !found_flag)
    else $error("first match without a fresh match");

  a_eos_clears: assert property (@(posedge clk) disable iff (rst)
    advance && item.end_of_string |=> char_counter == '0 && !found_flag
      && bytes_remaining == 2'd0)
    else $error("string state not cleared after last byte");

  a_seq_len: assert property (@(posedge clk) disable iff (rst)
    bytes_remaining != 2'd0 |-> SIZE_W'(bytes_remaining) < sequence_size)
    else $error("remaining count exceeds sequence length");
`endif

endmodule

// ===== src/u8drs_out_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8drs_out_reg
// result register holding one decoded character until it is taken
// ----------------------------------------------------------------------------
module u8drs_out_reg #(
  parameter int INDEX_WIDTH = u8drs_pkg::INDEX_W_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   advance,
  input  logic                   res_valid,
  input  u8drs_pkg::res_t        res,
  input  logic [INDEX_WIDTH-1:0] res_index,
  output logic                   out_ready,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output u8drs_pkg::res_t        out_res,
  output logic [INDEX_WIDTH-1:0] out_index
);
  import u8drs_pkg::*;

  logic load;

  assign out_ready = !m_tvalid || m_tready;
  assign load      = advance && res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_ready) begin
      m_tvalid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && load) begin
      out_res   <= res;
      out_index <= res_index;
    end
  end

endmodule

// ===== src/utf8_decode_rune_search_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_decode_rune_search_unit
// utf-8 byte stream decoder with single code point search
// ----------------------------------------------------------------------------
// usage:
//   bytes of a utf-8 string enter on the s_ group, one request per byte,
//   with s_tlast on the final byte of the string. each completed character
//   (or invalid lead byte, or a string cut off inside a sequence) leaves one
//   request on the m_ group; the earlier bytes of a sequence give none. m_tlast marks the
//   final result of a string and then carries any_found.
//   target code point and case rule are written on cfg_we/cfg_index/cfg_data
//   while no string is in flight.
//   a byte passes the input register, the combinational decode and compare,
//   and the result register before it leaves on m_. throughput: one byte per
//   cycle while m_tready does not stall the result register.
//   a stall on m_tready holds the result register and backs up into the
//   input register, then s_tready drops; nothing is lost.
//   reset clears the decode state, the index and the found flag, and sets
//   the target to 0 with case-sensitive compare.
// ----------------------------------------------------------------------------
module utf8_decode_rune_search_unit #(
  parameter int INDEX_WIDTH = u8drs_pkg::INDEX_W_DEF,
  localparam int OUT_DATA_W =
    ((u8drs_pkg::CP_W + u8drs_pkg::SIZE_W + INDEX_WIDTH + 3 + 7) / 8) * 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [u8drs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [u8drs_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [7:0]                         s_tdata,  // byte_in
  input  logic                               s_tlast,  // end_of_string
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // code_point, char_size, char_index, is_match, first_match_res, any_found
  output logic [OUT_DATA_W-1:0]              m_tdata,
  output logic [u8drs_pkg::OUT_USER_W-1:0]   m_tuser,  // bad_lead, truncated
  output logic                               m_tlast   // last
);
  import u8drs_pkg::*;

  item_t                  s_item, item;
  logic                   item_valid, advance, out_ready, res_valid;
  res_t                   res, out_res;
  logic [INDEX_WIDTH-1:0] res_index, out_index;

  assign s_item.byte_in       = s_tdata;
  assign s_item.end_of_string = s_tlast;

  u8drs_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_item     (s_item),
    .item_valid (item_valid),
    .item       (item),
    .advance    (advance)
  );

  u8drs_core #(.INDEX_WIDTH(INDEX_WIDTH)) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item       (item),
    .out_ready  (out_ready),
    .advance    (advance),
    .res_valid  (res_valid),
    .res        (res),
    .res_index  (res_index)
  );

  u8drs_out_reg #(.INDEX_WIDTH(INDEX_WIDTH)) u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .res_valid (res_valid),
    .res       (res),
    .res_index (res_index),
    .out_ready (out_ready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .out_res   (out_res),
    .out_index (out_index)
  );

  assign m_tdata = OUT_DATA_W'({out_res.any_found, out_res.first_match_res, out_res.is_match,
                                out_index, out_res.char_size, out_res.code_point});
  assign m_tuser = {out_res.truncated, out_res.bad_lead};
  assign m_tlast = out_res.last;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the utf-8 rune search unit: bytes are streamed in
// as strings, a local decoder predicts every character result, and a monitor
// compares each result field by field under random stalls on both sides
// ----------------------------------------------------------------------------
module tb;

  localparam int CP_W        = u8drs_pkg::CP_W;
  localparam int SIZE_W      = u8drs_pkg::SIZE_W;
  localparam int IDX_W       = u8drs_pkg::INDEX_W_DEF;
  localparam int OUT_W       = ((CP_W + SIZE_W + IDX_W + 3 + 7) / 8) * 8;
  localparam int SIZE_LO     = CP_W;
  localparam int IDX_LO      = CP_W + SIZE_W;
  localparam int FLAG_LO     = IDX_LO + IDX_W;
  localparam int QUIET_LIMIT = 2000;
  localparam logic [CP_W-1:0] CP_TOP = 21'h10FFFF;

  typedef struct packed {
    logic [CP_W-1:0]   cp;
    logic [SIZE_W-1:0] size;
    logic [IDX_W-1:0]  idx;
    logic              match;
    logic              first_hit;
    logic              bad;
    logic              trunc;
    logic              tail;
    logic              found;
  } rune_rec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [u8drs_pkg::CFG_IDX_W-1:0]  cfg_index = u8drs_pkg::CFG_TARGET;
  logic [u8drs_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic [u8drs_pkg::OUT_USER_W-1:0] m_tuser;
  logic m_tlast;

  utf8_decode_rune_search_unit #(.INDEX_WIDTH(IDX_W)) uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // search settings as last written
  logic [CP_W-1:0] tgt = '0;
  logic            case_exact = 1'b1;

  // decoder state of the predictor
  logic [1:0]        pend_left = '0;
  logic [SIZE_W-1:0] seq_len = '0;
  logic [CP_W-1:0]   part_cp = '0;
  logic [IDX_W-1:0]  char_cnt = '0;
  logic              str_found = 1'b0;

  rune_rec_t  runes_due [$];
  logic [7:0] str_bytes [$];
  int fail_count = 0;
  int bytes_sent = 0;
  int source_gap_pct = 0;
  int sink_stall_pct = 0;
  int sink_hold_req = 0;
  int sink_hold_left = 0;
  int quiet_cycles = 0;

  function automatic logic [SIZE_W-1:0] lead_len(input logic [7:0] b);
    casez (b)
      8'b0???????: lead_len = 3'd1;
      8'b110?????: lead_len = 3'd2;
      8'b1110????: lead_len = 3'd3;
      8'b11110???: lead_len = 3'd4;
      default:     lead_len = 3'd0;
    endcase
  endfunction

  function automatic logic [CP_W-1:0] ascii_lower(input logic [CP_W-1:0] c);
    if (c >= 21'h41 && c <= 21'h5A) return c + 21'h20;
    return c;
  endfunction

  function automatic int natural_len(input logic [CP_W-1:0] c);
    if (c < 21'h80) return 1;
    if (c < 21'h800) return 2;
    if (c < 21'h10000) return 3;
    return 4;
  endfunction

  // advance the decoder by one accepted byte, queue the character it completes
  function automatic void decode_byte(input logic [7:0] b, input logic eos);
    rune_rec_t r;
    logic done;
    logic [SIZE_W-1:0] len;
    r = '0;
    done = 1'b0;
    if (pend_left != 0) begin
      part_cp = {part_cp[CP_W-7:0], b[5:0]};
      pend_left = pend_left - 2'd1;
      if (pend_left == 0) begin
        done = 1'b1;
        r.cp = part_cp;
        r.size = seq_len;
      end
    end else begin
      len = lead_len(b);
      if (len == 0) begin
        done = 1'b1;
        r.bad = 1'b1;
      end else if (len == 1) begin
        done = 1'b1;
        r.cp = CP_W'(b[6:0]);
        r.size = 3'd1;
      end else begin
        seq_len = len;
        pend_left = 2'(len - 3'd1);
        part_cp = CP_W'(b & (8'h7F >> len));
      end
    end
    // string cut off inside a sequence
    if (!done && eos) begin
      done = 1'b1;
      r.trunc = 1'b1;
      r.cp = part_cp;
      r.size = seq_len;
    end
    if (done) begin
      if (!r.bad && !r.trunc) begin
        if (case_exact) r.match = (r.cp == tgt);
        else r.match = (ascii_lower(r.cp) == ascii_lower(tgt));
      end
      r.first_hit = r.match && !str_found;
      if (r.match) str_found = 1'b1;
      r.idx = char_cnt;
      if (char_cnt != '1) char_cnt = char_cnt + 1'b1;
      r.tail = eos;
      r.found = str_found;
      runes_due.push_back(r);
      if (r.trunc || eos) begin
        pend_left = '0;
        seq_len = '0;
        part_cp = '0;
      end
      if (eos) begin
        char_cnt = '0;
        str_found = 1'b0;
      end
    end
  endfunction

  function automatic void cmp_field(input string name, input int unsigned want,
                                    input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endfunction

  // result monitor
  always @(posedge clk) begin : result_check
    rune_rec_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (runes_due.size() == 0) begin
        $error("result with nothing expected: tdata %0h tuser %0h", m_tdata, m_tuser);
        fail_count++;
      end else begin
        want = runes_due.pop_front();
        cmp_field("code_point", want.cp, m_tdata[CP_W-1:0]);
        cmp_field("char_size", want.size, m_tdata[SIZE_LO +: SIZE_W]);
        cmp_field("char_index", want.idx, m_tdata[IDX_LO +: IDX_W]);
        cmp_field("is_match", want.match, m_tdata[FLAG_LO]);
        cmp_field("first_match_res", want.first_hit, m_tdata[FLAG_LO + 1]);
        cmp_field("any_found", want.found, m_tdata[FLAG_LO + 2]);
        cmp_field("bad_lead", want.bad, m_tuser[0]);
        cmp_field("truncated", want.trunc, m_tuser[1]);
        cmp_field("last", want.tail, m_tlast);
      end
    end
  end

  // result side ready, with random stalls and an optional long hold-off
  always @(posedge clk) begin
    if (sink_hold_req != 0) begin
      sink_hold_left = sink_hold_req;
      sink_hold_req = 0;
    end
    if (sink_hold_left != 0) begin
      sink_hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eos);
    while ($urandom_range(99) < source_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= eos;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    decode_byte(b, eos);
    bytes_sent++;
  endtask

  task automatic send_string();
    for (int i = 0; i < str_bytes.size(); i++) begin
      send_byte(str_bytes[i], i == str_bytes.size() - 1);
    end
  endtask

  // stop offering and wait for every outstanding result
  task automatic settle_results();
    s_tvalid <= 1'b0;
    while (runes_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_search(input logic [CP_W-1:0] t, input logic exact);
    cfg_we <= 1'b1;
    cfg_index <= u8drs_pkg::CFG_TARGET;
    cfg_data <= t;
    @(posedge clk);
    cfg_index <= u8drs_pkg::CFG_CASE;
    cfg_data <= u8drs_pkg::CFG_DATA_W'(exact);
    @(posedge clk);
    cfg_we <= 1'b0;
    tgt = t;
    case_exact = exact;
  endtask

  // append the first keep bytes of the len-byte encoding of c
  function automatic void push_char(input logic [CP_W-1:0] c, input int len, input int keep);
    logic [7:0] seq [4];
    seq = '{default: 8'h00};
    case (len)
      1: seq[0] = {1'b0, c[6:0]};
      2: begin
        seq[0] = {3'b110, c[10:6]};
        seq[1] = {2'b10, c[5:0]};
      end
      3: begin
        seq[0] = {4'b1110, c[15:12]};
        seq[1] = {2'b10, c[11:6]};
        seq[2] = {2'b10, c[5:0]};
      end
      default: begin
        seq[0] = {5'b11110, c[20:18]};
        seq[1] = {2'b10, c[17:12]};
        seq[2] = {2'b10, c[11:6]};
        seq[3] = {2'b10, c[5:0]};
      end
    endcase
    for (int i = 0; i < keep; i++) str_bytes.push_back(seq[i]);
  endfunction

  function automatic void compose_string();
    int nchars;
    int pick;
    int len;
    logic [CP_W-1:0] c;
    str_bytes.delete();
    nchars = $urandom_range(10, 1);
    repeat (nchars) begin
      pick = $urandom_range(99);
      if (pick < 20) begin
        // the target itself, at random case-flipped when folding applies
        c = tgt;
        if (!case_exact && ascii_lower(tgt) >= 21'h61 && ascii_lower(tgt) <= 21'h7A &&
            $urandom_range(1) == 1)
          c = tgt ^ 21'h20;
        push_char(c, natural_len(c), natural_len(c));
      end else if (pick < 45) begin
        push_char(CP_W'($urandom_range(8'h7F)), 1, 1);
      end else if (pick < 60) begin
        push_char(CP_W'($urandom_range(21'h7FF)), 2, 2);
      end else if (pick < 72) begin
        push_char(CP_W'($urandom_range(21'hFFFF)), 3, 3);
      end else if (pick < 82) begin
        push_char(CP_W'($urandom), 4, 4);
      end else if (pick < 90) begin
        if ($urandom_range(1) == 1) str_bytes.push_back(8'($urandom_range(8'hBF, 8'h80)));
        else str_bytes.push_back(8'($urandom_range(8'hFF, 8'hF8)));
      end else begin
        // lead followed by arbitrary bytes, taken as continuations anyway
        len = $urandom_range(4, 2);
        push_char(CP_W'($urandom), len, 1);
        repeat (len - 1) str_bytes.push_back(8'($urandom));
      end
    end
    if ($urandom_range(99) < 12) begin
      len = $urandom_range(4, 2);
      push_char(CP_W'($urandom), len, $urandom_range(len - 1, 1));
    end
  endfunction

  task automatic test_directed();
    source_gap_pct = 24;
    sink_stall_pct = 82;
    // reset search settings: target 0, exact; zero byte is a normal character
    str_bytes = '{8'h00, 8'h7F, 8'h80, 8'hFF, 8'h00};
    send_string();
    settle_results();
    load_search(21'h61, 1'b0);
    str_bytes = '{8'h41, 8'h61, 8'h5A, 8'hF8, 8'hC3, 8'hA9};
    send_string();
    settle_results();
    load_search(CP_TOP, 1'b1);
    // top code point, largest 4-byte value, unchecked continuation, cut-off ends
    str_bytes = '{8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'hF7, 8'hBF, 8'hBF, 8'hBF,
                  8'hC2, 8'h41, 8'hE2, 8'h82};
    send_string();
    str_bytes = '{8'hF0};
    send_string();
    settle_results();
  endtask

  task automatic test_random_traffic(input int gap_pct, input int stall_pct, input int items);
    int goal;
    int seg_goal;
    logic [CP_W-1:0] t;
    source_gap_pct = gap_pct;
    sink_stall_pct = stall_pct;
    goal = bytes_sent + items;
    while (bytes_sent < goal) begin
      case ($urandom_range(4))
        0: t = '0;
        1: t = CP_TOP;
        2: t = CP_W'($urandom_range(8'h5A, 8'h41));
        3: t = CP_W'($urandom_range(8'h7A, 8'h61));
        default: t = CP_W'($urandom_range(CP_TOP));
      endcase
      load_search(t, 1'($urandom_range(1)));
      seg_goal = bytes_sent + 70;
      while (bytes_sent < seg_goal && bytes_sent < goal) begin
        compose_string();
        send_string();
      end
      settle_results();
    end
  endtask

  task automatic test_backpressure();
    int goal;
    source_gap_pct = 0;
    sink_stall_pct = 0;
    load_search(21'h45, 1'b0);
    sink_hold_req = 300;
    goal = bytes_sent + 40;
    while (bytes_sent < goal) begin
      compose_string();
      send_string();
    end
    settle_results();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_traffic(24, 82, 180);
    test_random_traffic(82, 24, 180);
    test_random_traffic(0, 0, 180);
    test_backpressure();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
